// File: rtl/i2da_pkg.sv
// ----------------------------------------------------------------------------
// i2da_pkg: shared types and constants for the integer-to-text converter
// Request and result formats, value kind codes, job format and text tables.
// ----------------------------------------------------------------------------
package i2da_pkg;

    // Value kind codes carried by a request.
    localparam logic [1:0] KIND_NULL  = 2'd0;
    localparam logic [1:0] KIND_BOOL  = 2'd1;
    localparam logic [1:0] KIND_INT   = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    localparam int INT_W      = 64;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 20;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    // The divide-by-ten unit consumes this many dividend bits per cycle.
    localparam int CHUNK_W = 8;
    localparam int CHUNKS  = INT_W / CHUNK_W;
    localparam int STEP_W  = $clog2(CHUNKS);

    // Job queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_ZERO  = "0";
    localparam logic [CHAR_W-1:0] CH_MINUS = "-";
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

    typedef struct packed {
        logic [1:0]              value_kind;
        logic                    bool_value;
        logic signed [INT_W-1:0] int_value;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic              not_printable;
    } text_t;

    typedef enum logic [2:0] {
        JOB_NULL  = 3'd0,
        JOB_TRUE  = 3'd1,
        JOB_FALSE = 3'd2,
        JOB_INT   = 3'd3,
        JOB_ERR   = 3'd4
    } job_kind_t;

    typedef struct packed {
        job_kind_t        kind;
        logic             negative;
        logic [INT_W-1:0] magnitude;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Character at position idx of the fixed word for a text job.
    function automatic logic [CHAR_W-1:0] text_char(job_kind_t kind, logic [2:0] idx);
        logic [CHAR_W-1:0] c;
        c = CH_NONE;
        case (kind)
            JOB_NULL:
            begin
                case (idx)
                    3'd0:    c = "n";
                    3'd1:    c = "u";
                    3'd2:    c = "l";
                    3'd3:    c = "l";
                    default: c = CH_NONE;
                endcase
            end
            JOB_TRUE:
            begin
                case (idx)
                    3'd0:    c = "t";
                    3'd1:    c = "r";
                    3'd2:    c = "u";
                    3'd3:    c = "e";
                    default: c = CH_NONE;
                endcase
            end
            JOB_FALSE:
            begin
                case (idx)
                    3'd0:    c = "f";
                    3'd1:    c = "a";
                    3'd2:    c = "l";
                    3'd3:    c = "s";
                    3'd4:    c = "e";
                    default: c = CH_NONE;
                endcase
            end
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

    // Index of the final character of the fixed word for a text job.
    function automatic logic [2:0] text_last_idx(job_kind_t kind);
        logic [2:0] n;
        case (kind)
            JOB_FALSE: n = 3'd4;
            default:   n = 3'd3;
        endcase
        return n;
    endfunction

endpackage

// File: rtl/i2da_front.sv
// ----------------------------------------------------------------------------
// i2da_front: request classifier
// Sorts each request into a job kind and takes the magnitude of integers.
// ----------------------------------------------------------------------------
module i2da_front
(
    input  i2da_pkg::item_t   item,
    input  logic              item_valid,
    output logic              item_ready,
    input  i2da_pkg::q_stat_t stat,
    output logic              push,
    output i2da_pkg::job_t    job
);

    logic                       negative;
    logic [i2da_pkg::INT_W-1:0] raw;

    // The magnitude is formed in unsigned arithmetic, so the most negative
    // value maps to 2**63 without overflow.
    assign raw      = item.int_value;
    assign negative = raw[i2da_pkg::INT_W-1];

    assign item_ready = !stat.full;
    assign push       = item_valid && !stat.full;

    always_comb
    begin
        job.negative  = 1'b0;
        job.magnitude = raw;
        case (item.value_kind)
            i2da_pkg::KIND_NULL: job.kind = i2da_pkg::JOB_NULL;
            i2da_pkg::KIND_BOOL:
            begin
                job.kind = item.bool_value ? i2da_pkg::JOB_TRUE : i2da_pkg::JOB_FALSE;
            end
            i2da_pkg::KIND_INT:
            begin
                job.kind      = i2da_pkg::JOB_INT;
                job.negative  = negative;
                job.magnitude = negative ? (~raw + 1'b1) : raw;
            end
            default: job.kind = i2da_pkg::JOB_ERR;
        endcase
    end

endmodule

// File: rtl/i2da_queue.sv
// ----------------------------------------------------------------------------
// i2da_queue: job queue
// A short first-in first-out queue that decouples the classifier from the
// character generator.
// ----------------------------------------------------------------------------
module i2da_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  i2da_pkg::job_t    job_in,
    input  logic              pop,
    output i2da_pkg::job_t    job_out,
    output i2da_pkg::q_stat_t stat
);

    i2da_pkg::job_t                entry_reg [i2da_pkg::QDEPTH];
    logic [i2da_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [i2da_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [i2da_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [i2da_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [i2da_pkg::QCNT_W-1:0]   cnt_reg;
    logic [i2da_pkg::QCNT_W-1:0]   cnt_next;

    localparam logic [i2da_pkg::QPTR_W-1:0] PTR_END = i2da_pkg::QPTR_W'(i2da_pkg::QDEPTH - 1);
    localparam logic [i2da_pkg::QCNT_W-1:0] CNT_FULL = i2da_pkg::QCNT_W'(i2da_pkg::QDEPTH);

    assign stat.full  = (cnt_reg == CNT_FULL);
    assign stat.empty = (cnt_reg == '0);
    assign job_out    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_END) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_END) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

// File: rtl/i2da_back.sv
// ----------------------------------------------------------------------------
// i2da_back: character generator
// Takes jobs from the queue, extracts decimal digits by repeated division by
// ten, and emits the text one character at a time through an output register.
// ----------------------------------------------------------------------------
module i2da_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  i2da_pkg::q_stat_t stat,
    input  i2da_pkg::job_t    job,
    output logic              pop,
    output logic              text_valid,
    input  logic              text_ready,
    output i2da_pkg::text_t   text
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    localparam int INT_W   = i2da_pkg::INT_W;
    localparam int CHUNK_W = i2da_pkg::CHUNK_W;
    localparam int DIGIT_W = i2da_pkg::DIGIT_W;
    localparam int NDIG    = i2da_pkg::MAX_DIGITS;

    localparam logic [i2da_pkg::STEP_W-1:0] STEP_LAST = i2da_pkg::STEP_W'(i2da_pkg::CHUNKS - 1);
    localparam logic [i2da_pkg::CNT_W-1:0]  CNT_LAST  = i2da_pkg::CNT_W'(NDIG - 1);
    localparam logic [i2da_pkg::CNT_W-1:0]  CNT_MAX   = i2da_pkg::CNT_W'(NDIG);

    state_t                        state_reg;
    state_t                        state_next;
    i2da_pkg::job_kind_t           mode_reg;
    i2da_pkg::job_kind_t           mode_next;
    logic                          neg_reg;
    logic                          neg_next;
    logic [INT_W-1:0]              work_reg;
    logic [INT_W-1:0]              work_next;
    logic [DIGIT_W-1:0]            rem_reg;
    logic [DIGIT_W-1:0]            rem_next;
    logic [i2da_pkg::STEP_W-1:0]   step_reg;
    logic [i2da_pkg::STEP_W-1:0]   step_next;
    logic [DIGIT_W-1:0]            dig_reg  [NDIG];
    logic [DIGIT_W-1:0]            dig_next [NDIG];
    logic [i2da_pkg::CNT_W-1:0]    cnt_reg;
    logic [i2da_pkg::CNT_W-1:0]    cnt_next;
    logic [2:0]                    idx_reg;
    logic [2:0]                    idx_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    i2da_pkg::text_t               out_reg;
    i2da_pkg::text_t               out_next;

    logic [DIGIT_W:0]              trial;
    logic [DIGIT_W-1:0]            div_rem;
    logic [CHUNK_W-1:0]            div_q;
    logic [INT_W-1:0]              div_work;
    logic                          emit_fire;
    i2da_pkg::text_t               emit;

    assign text_valid = out_valid_reg;
    assign text       = out_reg;

    // One chunk of restoring long division by ten: the remainder always stays
    // below ten, so each bit step is a five-bit compare and subtract. Quotient
    // bits replace the consumed dividend bits at the bottom of the word.
    always_comb
    begin
        div_rem = rem_reg;
        div_q   = '0;
        trial   = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--)
        begin
            trial = {div_rem, work_reg[INT_W - CHUNK_W + i]};
            if (trial >= (DIGIT_W + 1)'(10))
            begin
                trial    = trial - (DIGIT_W + 1)'(10);
                div_q[i] = 1'b1;
            end
            div_rem = trial[DIGIT_W-1:0];
        end
        div_work = {work_reg[INT_W-CHUNK_W-1:0], div_q};
    end

    // Character for the current emit cycle.
    always_comb
    begin
        emit.not_printable = 1'b0;
        case (mode_reg)
            i2da_pkg::JOB_INT:
            begin
                if (neg_reg)
                begin
                    emit.char_code = i2da_pkg::CH_MINUS;
                    emit.last      = 1'b0;
                end
                else
                begin
                    emit.char_code = i2da_pkg::CH_ZERO
                                   + {{(i2da_pkg::CHAR_W - DIGIT_W){1'b0}}, dig_reg[0]};
                    emit.last      = (cnt_reg == i2da_pkg::CNT_W'(1));
                end
            end
            i2da_pkg::JOB_ERR:
            begin
                emit.char_code     = i2da_pkg::CH_NONE;
                emit.last          = 1'b1;
                emit.not_printable = 1'b1;
            end
            default:
            begin
                emit.char_code = i2da_pkg::text_char(mode_reg, idx_reg);
                emit.last      = (idx_reg == i2da_pkg::text_last_idx(mode_reg));
            end
        endcase
    end

    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || text_ready);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        neg_next       = neg_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        dig_next       = dig_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pop            = 1'b0;

        if (text_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!stat.empty)
                begin
                    pop        = 1'b1;
                    mode_next  = job.kind;
                    neg_next   = job.negative;
                    work_next  = job.magnitude;
                    rem_next   = '0;
                    step_next  = '0;
                    cnt_next   = '0;
                    idx_next   = '0;
                    state_next = (job.kind == i2da_pkg::JOB_INT) ? ST_DIV : ST_EMIT;
                end
            end
            ST_DIV:
            begin
                work_next = div_work;
                rem_next  = div_rem;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    // A digit is complete: push it in front of the older ones,
                    // so the most significant digit sits at the head.
                    for (int i = 1; i < NDIG; i++)
                    begin
                        dig_next[i] = dig_reg[i-1];
                    end
                    dig_next[0] = div_rem;
                    cnt_next    = cnt_reg + 1'b1;
                    rem_next    = '0;
                    step_next   = '0;
                    if ((div_work == '0) || (cnt_reg == CNT_LAST))
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    out_next       = emit;
                    if (mode_reg == i2da_pkg::JOB_INT)
                    begin
                        if (neg_reg)
                        begin
                            neg_next = 1'b0;
                        end
                        else
                        begin
                            for (int i = 0; i < NDIG - 1; i++)
                            begin
                                dig_next[i] = dig_reg[i+1];
                            end
                            cnt_next = cnt_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    if (emit.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= i2da_pkg::JOB_NULL;
            neg_reg       <= 1'b0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            neg_reg       <= neg_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dig_reg  <= dig_next;
        out_reg  <= out_next;
    end

    // The digit count never exceeds the longest possible number.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("digit count out of range");

    // While digits are being emitted there is always at least one left.
    a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && (mode_reg == i2da_pkg::JOB_INT) && !neg_reg
        |-> cnt_reg != '0)
        else $error("emitting a digit from an empty digit store");

    // Each finished division adds exactly one digit.
    a_digit_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && (step_reg == STEP_LAST)
        |=> cnt_reg == i2da_pkg::CNT_W'($past(cnt_reg) + 1'b1))
        else $error("digit count did not advance after a division");

    // The error result is a single zero character that closes the text.
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.not_printable
        |-> out_reg.last && (out_reg.char_code == i2da_pkg::CH_NONE))
        else $error("malformed not-printable result");

endmodule

// File: rtl/int64_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii: tagged value to ASCII text converter
// Turns one tagged value per request into its printable text, one character
// per result, most significant first, with a last marker on the final one.
// ----------------------------------------------------------------------------
// A request carries a value kind and its payload. Null gives "null", a boolean
// gives "true" or "false", a signed 64-bit integer gives an optional minus
// sign and its decimal digits without leading zeros (the most negative value
// included), and any other kind gives a single result with char_code zero,
// last set and not_printable set. A classifier at the front accepts a request
// whenever the two-entry job queue has room, so up to two requests can be
// taken while an earlier one is still being converted; the character
// generator behind the queue works on one job at a time. Integer conversion
// runs a divide-by-ten unit that consumes eight dividend bits per cycle;
// each decimal digit needs a pass over the whole 64-bit word. An integer job
// leaves the queue, is divided once per digit (up to nineteen digits), then is
// emitted one character at a time, minus sign first; a word kind is spelled out
// and the error kind gives one result. Characters sit in an output register,
// so a stalled consumer holds back the generator and, once the job queue is
// full, the front. A new character can follow every cycle while the consumer
// keeps text_ready high. Nothing is kept from one request to the next.
// ----------------------------------------------------------------------------
module int64_to_decimal_ascii
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  i2da_pkg::item_t item,
    output logic            text_valid,
    input  logic            text_ready,
    output i2da_pkg::text_t text
);

    i2da_pkg::job_t    front_job;
    i2da_pkg::job_t    head_job;
    i2da_pkg::q_stat_t q_stat;
    logic              q_push;
    logic              q_pop;

    // Front: classify the request and form the integer magnitude.
    i2da_front u_front
    (
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (q_stat),
        .push       (q_push),
        .job        (front_job)
    );

    // Queue: lets the front keep accepting while the back is busy.
    i2da_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .job_in  (front_job),
        .pop     (q_pop),
        .job_out (head_job),
        .stat    (q_stat)
    );

    // Back: digit extraction and character emission.
    i2da_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .stat       (q_stat),
        .job        (head_job),
        .pop        (q_pop),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text       (text)
    );

endmodule

// File: tb/sv/tb_int64_to_decimal_ascii.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_int64_to_decimal_ascii: self-checking testbench for the value-to-text block
// Sends tagged values through the request channel and checks every character
// that comes back against a local prediction, in order and field by field.
// Covers the null, boolean, integer and unprintable kinds, the edge integers,
// random traffic, idle gaps on both channels and a long consumer hold-off.
// ----------------------------------------------------------------------------
module tb_int64_to_decimal_ascii;

    logic            clk;
    logic            rst_n;
    logic            item_valid;
    logic            item_ready;
    i2da_pkg::item_t item;
    logic            text_valid;
    logic            text_ready;
    i2da_pkg::text_t text;

    // Characters the block still owes us, oldest first.
    i2da_pkg::text_t pending_chars[$];
    int              mismatch_count;

    // Idle controls. The sender and the receiver each insert random gaps
    // while their flag is set. hold_off_cycles forces the receiver to keep
    // text_ready low for that many cycles; it is counted down by the
    // receiver process itself.
    bit producer_idles;
    bit consumer_idles;
    int hold_off_cycles;

    int64_to_decimal_ascii DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text       (text)
    );

    always #5 clk = ~clk;

    // Gap length for either side: usually none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic i2da_pkg::item_t make_item(logic [1:0] kind, logic flag,
                                                  logic signed [63:0] num);
        i2da_pkg::item_t v;
        v.value_kind = kind;
        v.bool_value = flag;
        v.int_value  = num;
        return v;
    endfunction

    // Works out the text of one value and queues its characters. The integer
    // magnitude is taken in unsigned arithmetic, so the most negative value
    // comes out as 2**63 without overflow. Payloads of the wrong kind are
    // simply ignored.
    function automatic void predict_text(i2da_pkg::item_t v);
        byte unsigned    chars[$];
        string           word;
        logic [63:0]     mag;
        i2da_pkg::text_t t;
        word = "";
        case (v.value_kind)
            i2da_pkg::KIND_NULL: word = "null";
            i2da_pkg::KIND_BOOL: word = v.bool_value ? "true" : "false";
            i2da_pkg::KIND_INT:
            begin
                mag = v.int_value[63] ? (~v.int_value + 64'd1) : v.int_value;
                do
                begin
                    chars.push_front(i2da_pkg::CH_ZERO + 8'(mag % 64'd10));
                    mag = mag / 64'd10;
                end
                while (mag != 64'd0);
                if (v.int_value[63])
                    chars.push_front(i2da_pkg::CH_MINUS);
            end
            default: ;
        endcase
        for (int i = 0; i < word.len(); i++)
            chars.push_back(word[i]);

        if (v.value_kind == i2da_pkg::KIND_OTHER)
        begin
            // An unprintable kind yields exactly one flagged, empty character.
            t.char_code     = i2da_pkg::CH_NONE;
            t.last          = 1'b1;
            t.not_printable = 1'b1;
            pending_chars.push_back(t);
        end
        else
        begin
            for (int i = 0; i < chars.size(); i++)
            begin
                t.char_code     = chars[i];
                t.last          = (i == chars.size() - 1);
                t.not_printable = 1'b0;
                pending_chars.push_back(t);
            end
        end
    endfunction

    // Random value. Integers dominate since they exercise the divider; the
    // payload fields are always random so unused payloads get covered too.
    function automatic i2da_pkg::item_t random_value();
        i2da_pkg::item_t    v;
        int                 r;
        logic signed [63:0] p;
        v.bool_value = $urandom_range(0, 1);
        v.int_value  = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 10)
            v.value_kind = i2da_pkg::KIND_NULL;
        else if (r < 25)
            v.value_kind = i2da_pkg::KIND_BOOL;
        else if (r < 90)
            v.value_kind = i2da_pkg::KIND_INT;
        else
            v.value_kind = i2da_pkg::KIND_OTHER;

        if (v.value_kind == i2da_pkg::KIND_INT)
        begin
            case ($urandom_range(0, 3))
                0: ;  // full 64-bit random
                1: v.int_value = $urandom_range(0, 99);
                2: v.int_value = 64'(signed'($urandom));
                default:
                begin
                    // Just around a power of ten, where the digit count changes.
                    p = 64'sd1;
                    repeat ($urandom_range(0, 18))
                        p = p * 64'sd10;
                    v.int_value = p + $urandom_range(0, 2) - 1;
                end
            endcase
            if (r < 60 && v.int_value > 0)
                v.int_value = -v.int_value;
        end
        return v;
    endfunction

    // Offers one request and returns at the edge where it is taken. Valid is
    // left high on return; the next call either keeps it high (no gap) or
    // drops it in this same step before idling.
    task automatic send_value(input i2da_pkg::item_t v);
        int gap;
        gap = producer_idles ? pick_gap() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= v;
        do
            @(posedge clk);
        while (!item_ready);
        predict_text(v);
    endtask

    // Drops valid and waits until every predicted character has come back.
    // Anything still missing after a generous bound is reported and dropped
    // so the run can carry on.
    task automatic wait_drained();
        int waited;
        waited = 0;
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_chars.size() != 0)
        begin
            $display("%0t: %0d characters missing, expected %h, actual none",
                     $time, pending_chars.size(), pending_chars[0]);
            mismatch_count++;
            pending_chars.delete();
        end
    endtask

    // Null, both booleans and the unprintable kind, with and without junk in
    // the payload fields that do not belong to the kind.
    task automatic test_word_kinds();
        producer_idles = 1'b0;
        consumer_idles = 1'b0;
        send_value(make_item(i2da_pkg::KIND_NULL, 1'b0, 64'sd0));
        send_value(make_item(i2da_pkg::KIND_NULL, 1'b1, -64'sd1));
        send_value(make_item(i2da_pkg::KIND_BOOL, 1'b1, 64'sd0));
        send_value(make_item(i2da_pkg::KIND_BOOL, 1'b0, 64'sd0));
        send_value(make_item(i2da_pkg::KIND_BOOL, 1'b1, 64'sh7FFF_FFFF_FFFF_FFFF));
        send_value(make_item(i2da_pkg::KIND_OTHER, 1'b0, 64'sd0));
        send_value(make_item(i2da_pkg::KIND_OTHER, 1'b1, -64'sd1));
        wait_drained();
    endtask

    // Zero, single digits, digit-count boundaries and both ends of the range,
    // the most negative value among them.
    task automatic test_integer_edges();
        producer_idles = 1'b1;
        consumer_idles = 1'b1;
        send_value(make_item(i2da_pkg::KIND_INT, 1'b0, 64'sd0));
        send_value(make_item(i2da_pkg::KIND_INT, 1'b0, 64'sd1));
        send_value(make_item(i2da_pkg::KIND_INT, 1'b1, -64'sd1));
        send_value(make_item(i2da_pkg::KIND_INT, 1'b0, 64'sd9));
        send_value(make_item(i2da_pkg::KIND_INT, 1'b0, 64'sd10));
        send_value(make_item(i2da_pkg::KIND_INT, 1'b0, -64'sd10));
        send_value(make_item(i2da_pkg::KIND_INT, 1'b0, 64'sd999_999_999_999_999_999));
        send_value(make_item(i2da_pkg::KIND_INT, 1'b0, 64'sd1_000_000_000_000_000_000));
        send_value(make_item(i2da_pkg::KIND_INT, 1'b0, 64'sh7FFF_FFFF_FFFF_FFFF));
        send_value(make_item(i2da_pkg::KIND_INT, 1'b0, 64'sh8000_0000_0000_0000));
        send_value(make_item(i2da_pkg::KIND_INT, 1'b1, 64'sh8000_0000_0000_0001));
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering back to back, so the job queue and output register fill up and
    // item_ready has to drop. Long integers make the back end slowest.
    task automatic test_full_consumer_stall();
        producer_idles  = 1'b0;
        consumer_idles  = 1'b0;
        hold_off_cycles = 400;
        send_value(make_item(i2da_pkg::KIND_INT, 1'b0, 64'sh8000_0000_0000_0000));
        send_value(make_item(i2da_pkg::KIND_INT, 1'b0, 64'sh7FFF_FFFF_FFFF_FFFF));
        send_value(make_item(i2da_pkg::KIND_BOOL, 1'b0, 64'sd0));
        send_value(make_item(i2da_pkg::KIND_OTHER, 1'b0, 64'sd0));
        repeat (6)
            send_value(random_value());
        wait_drained();
    endtask

    // Random traffic in phases. Each phase takes the next of four idle patterns,
    // and the sender pauses until everything is back between phases.
    task automatic test_random_values();
        for (int i = 0; i < 300; i++)
        begin
            if (i % 50 == 0)
            begin
                if (i > 0)
                    wait_drained();
                case ((i / 50) % 4)
                    0: begin producer_idles = 1'b1; consumer_idles = 1'b1; end
                    1: begin producer_idles = 1'b0; consumer_idles = 1'b0; end
                    2: begin producer_idles = 1'b1; consumer_idles = 1'b0; end
                    default: begin producer_idles = 1'b0; consumer_idles = 1'b1; end
                endcase
            end
            send_value(random_value());
        end
        wait_drained();
    endtask

    // Receiver: drives text_ready at each rising edge.
    initial
    begin
        int gap_left;
        gap_left   = 0;
        text_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                text_ready <= 1'b0;
                hold_off_cycles--;
            end
            else if (gap_left > 0)
            begin
                text_ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                text_ready <= 1'b1;
                if (consumer_idles)
                    gap_left = pick_gap();
            end
        end
    end

    // Checker: every accepted character is compared with the oldest one
    // predicted. Sampling happens at the edge, before any update at it.
    always @(posedge clk)
    begin
        i2da_pkg::text_t want;
        if (rst_n && text_valid && text_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected character, expected none, actual %h",
                         $time, text);
                mismatch_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (text.char_code !== want.char_code)
                begin
                    $display("%0t: char_code mismatch, expected %h, actual %h",
                             $time, want.char_code, text.char_code);
                    mismatch_count++;
                end
                if (text.last !== want.last)
                begin
                    $display("%0t: last mismatch, expected %b, actual %b",
                             $time, want.last, text.last);
                    mismatch_count++;
                end
                if (text.not_printable !== want.not_printable)
                begin
                    $display("%0t: not_printable mismatch, expected %b, actual %b",
                             $time, want.not_printable, text.not_printable);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("tb_int64_to_decimal_ascii failed");
        $finish;
    end

    // Main sequence.
    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        item_valid      = 1'b0;
        item            = '0;
        mismatch_count  = 0;
        producer_idles  = 1'b0;
        consumer_idles  = 1'b0;
        hold_off_cycles = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_word_kinds();
        test_integer_edges();
        test_full_consumer_stall();
        test_random_values();

        // Let any stray character show up before the verdict.
        repeat (200) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_int64_to_decimal_ascii passed");
        else
            $display("tb_int64_to_decimal_ascii failed");
        $finish;
    end

endmodule
